// ===== rtl/core/cdsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsd_pkg: shared types and control store for the card deck dealer
// Item structs, control word fields and the read-only program of the
// sequencer.
// ----------------------------------------------------------------------------
package cdsd_pkg;

  localparam int RNDW = 31;                // random word width
  localparam int BITW = $clog2(RNDW);      // remainder step counter width
  localparam int UAW  = 5;                 // control store address width

  typedef struct packed {
    logic [2:0]      command;
    logic [RNDW-1:0] random_value;
    logic [7:0]      card_id;
  } in_t;

  typedef struct packed {
    logic [7:0] card;
    logic [6:0] cards_remaining;
    logic       deck_empty;
    logic [1:0] status;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    CMD_RESTACK = 3'd0,
    CMD_SHUFFLE = 3'd1,
    CMD_DEAL    = 3'd2,
    CMD_HAND    = 3'd3,
    CMD_PEEK    = 3'd4,
    CMD_REPLACE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DONE  = 2'd2
  } status_e;

  // sequencing of one step
  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_BRANCH,
    SEQ_DISPATCH,
    SEQ_END
  } seq_e;

  // branch condition select
  typedef enum logic [2:0] {
    C_EMPTY,
    C_FEW,
    C_SHUF_DONE,
    C_FILL_LAST,
    C_DIV_LAST,
    C_HAND_LAST
  } cond_e;

  // datapath action of one step
  typedef enum logic [3:0] {
    A_NONE,
    A_IDX_CLR,
    A_RS_WR,
    A_RS_FIN,
    A_DIV_INIT,
    A_DIV_STEP,
    A_PICK,
    A_HOLD,
    A_SW1,
    A_SW2,
    A_DEC,
    A_RD_TOP,
    A_LOAD,
    A_IDX_INC,
    A_RD_BOT,
    A_WR_BOT
  } act_e;

  // result produced by a step
  typedef enum logic [2:0] {
    EM_NONE,
    EM_OK,
    EM_UNDER,
    EM_DONE,
    EM_CARD,
    EM_HAND
  } emit_e;

  typedef struct packed {
    seq_e           seq;
    cond_e          cond;
    logic           inv;
    logic [UAW-1:0] target;
    act_e           act;
    emit_e          emit;
  } ucode_t;

  // condition flags from the datapath
  typedef struct packed {
    logic empty_deck;
    logic few_cards;
    logic shuf_done;
    logic fill_last;
    logic div_last;
    logic hand_last;
  } flags_t;

  // program addresses
  localparam logic [UAW-1:0] U_DISPATCH = 5'd0;
  localparam logic [UAW-1:0] U_RS_INIT  = 5'd1;
  localparam logic [UAW-1:0] U_RS_WR    = 5'd2;
  localparam logic [UAW-1:0] U_RS_FIN   = 5'd3;
  localparam logic [UAW-1:0] U_E_OK     = 5'd4;
  localparam logic [UAW-1:0] U_E_UNDER  = 5'd5;
  localparam logic [UAW-1:0] U_E_DONE   = 5'd6;
  localparam logic [UAW-1:0] U_E_CARD   = 5'd7;
  localparam logic [UAW-1:0] U_SH_CHK0  = 5'd8;
  localparam logic [UAW-1:0] U_SH_CHK1  = 5'd9;
  localparam logic [UAW-1:0] U_SH_DINIT = 5'd10;
  localparam logic [UAW-1:0] U_SH_DSTEP = 5'd11;
  localparam logic [UAW-1:0] U_SH_PICK  = 5'd12;
  localparam logic [UAW-1:0] U_SH_HOLD  = 5'd13;
  localparam logic [UAW-1:0] U_SH_SW1   = 5'd14;
  localparam logic [UAW-1:0] U_SH_SW2   = 5'd15;
  localparam logic [UAW-1:0] U_DT_CHK   = 5'd16;
  localparam logic [UAW-1:0] U_DT_DEC   = 5'd17;
  localparam logic [UAW-1:0] U_DT_RD    = 5'd18;
  localparam logic [UAW-1:0] U_DT_LD    = 5'd19;
  localparam logic [UAW-1:0] U_DH_CHK   = 5'd20;
  localparam logic [UAW-1:0] U_DH_INIT  = 5'd21;
  localparam logic [UAW-1:0] U_DH_DEC   = 5'd22;
  localparam logic [UAW-1:0] U_DH_RD    = 5'd23;
  localparam logic [UAW-1:0] U_DH_LD    = 5'd24;
  localparam logic [UAW-1:0] U_DH_EMIT  = 5'd25;
  localparam logic [UAW-1:0] U_DH_END   = 5'd26;
  localparam logic [UAW-1:0] U_PK_CHK   = 5'd27;
  localparam logic [UAW-1:0] U_PK_RD    = 5'd28;
  localparam logic [UAW-1:0] U_PK_LD    = 5'd29;
  localparam logic [UAW-1:0] U_RP_CHK   = 5'd30;
  localparam logic [UAW-1:0] U_RP_WR    = 5'd31;

  function automatic ucode_t uw(seq_e seq, cond_e cond, logic inv,
                                logic [UAW-1:0] target, act_e act, emit_e emit);
    ucode_t w;
    w.seq    = seq;
    w.cond   = cond;
    w.inv    = inv;
    w.target = target;
    w.act    = act;
    w.emit   = emit;
    return w;
  endfunction

  localparam ucode_t UW_NOP = '{seq: SEQ_NEXT, cond: C_EMPTY, inv: 1'b0,
                                target: U_DISPATCH, act: A_NONE, emit: EM_NONE};

  function automatic ucode_t ucode_rom(logic [UAW-1:0] upc);
    ucode_t w;
    w = UW_NOP;
    unique case (upc)
      U_DISPATCH: w = uw(SEQ_DISPATCH, C_EMPTY, 1'b0, U_DISPATCH, A_NONE, EM_NONE);
      // restack: fill every position with its own index
      U_RS_INIT:  w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_IDX_CLR, EM_NONE);
      U_RS_WR:    w = uw(SEQ_BRANCH, C_FILL_LAST, 1'b1, U_RS_WR,    A_RS_WR,   EM_NONE);
      U_RS_FIN:   w = uw(SEQ_JUMP,   C_EMPTY,     1'b0, U_E_OK,     A_RS_FIN,  EM_NONE);
      // single-result endings
      U_E_OK:     w = uw(SEQ_END, C_EMPTY, 1'b0, U_DISPATCH, A_NONE, EM_OK);
      U_E_UNDER:  w = uw(SEQ_END, C_EMPTY, 1'b0, U_DISPATCH, A_NONE, EM_UNDER);
      U_E_DONE:   w = uw(SEQ_END, C_EMPTY, 1'b0, U_DISPATCH, A_NONE, EM_DONE);
      U_E_CARD:   w = uw(SEQ_END, C_EMPTY, 1'b0, U_DISPATCH, A_NONE, EM_CARD);
      // shuffle step: empty and done checks, remainder, then swap
      U_SH_CHK0:  w = uw(SEQ_BRANCH, C_EMPTY,     1'b0, U_E_UNDER,  A_NONE,     EM_NONE);
      U_SH_CHK1:  w = uw(SEQ_BRANCH, C_SHUF_DONE, 1'b0, U_E_DONE,   A_NONE,     EM_NONE);
      U_SH_DINIT: w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_DIV_INIT, EM_NONE);
      U_SH_DSTEP: w = uw(SEQ_BRANCH, C_DIV_LAST,  1'b1, U_SH_DSTEP, A_DIV_STEP, EM_NONE);
      U_SH_PICK:  w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_PICK,     EM_NONE);
      U_SH_HOLD:  w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_HOLD,     EM_NONE);
      U_SH_SW1:   w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_SW1,      EM_NONE);
      U_SH_SW2:   w = uw(SEQ_JUMP,   C_EMPTY,     1'b0, U_E_OK,     A_SW2,      EM_NONE);
      // deal top
      U_DT_CHK:   w = uw(SEQ_BRANCH, C_EMPTY, 1'b0, U_E_UNDER,  A_NONE,   EM_NONE);
      U_DT_DEC:   w = uw(SEQ_NEXT,   C_EMPTY, 1'b0, U_DISPATCH, A_DEC,    EM_NONE);
      U_DT_RD:    w = uw(SEQ_NEXT,   C_EMPTY, 1'b0, U_DISPATCH, A_RD_TOP, EM_NONE);
      U_DT_LD:    w = uw(SEQ_JUMP,   C_EMPTY, 1'b0, U_E_CARD,   A_LOAD,   EM_NONE);
      // deal hand
      U_DH_CHK:   w = uw(SEQ_BRANCH, C_FEW,       1'b0, U_E_UNDER,  A_NONE,    EM_NONE);
      U_DH_INIT:  w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_IDX_CLR, EM_NONE);
      U_DH_DEC:   w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_DEC,     EM_NONE);
      U_DH_RD:    w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_RD_TOP,  EM_NONE);
      U_DH_LD:    w = uw(SEQ_NEXT,   C_EMPTY,     1'b0, U_DISPATCH, A_LOAD,    EM_NONE);
      U_DH_EMIT:  w = uw(SEQ_BRANCH, C_HAND_LAST, 1'b1, U_DH_DEC,   A_IDX_INC, EM_HAND);
      U_DH_END:   w = uw(SEQ_END,    C_EMPTY,     1'b0, U_DISPATCH, A_NONE,    EM_NONE);
      // peek bottom
      U_PK_CHK:   w = uw(SEQ_BRANCH, C_EMPTY, 1'b0, U_E_UNDER,  A_NONE,   EM_NONE);
      U_PK_RD:    w = uw(SEQ_NEXT,   C_EMPTY, 1'b0, U_DISPATCH, A_RD_BOT, EM_NONE);
      U_PK_LD:    w = uw(SEQ_JUMP,   C_EMPTY, 1'b0, U_E_CARD,   A_LOAD,   EM_NONE);
      // replace bottom
      U_RP_CHK:   w = uw(SEQ_BRANCH, C_EMPTY, 1'b0, U_E_UNDER, A_NONE,   EM_NONE);
      U_RP_WR:    w = uw(SEQ_JUMP,   C_EMPTY, 1'b0, U_E_OK,    A_WR_BOT, EM_NONE);
      default:    w = UW_NOP;
    endcase
    return w;
  endfunction

  function automatic logic [UAW-1:0] dispatch(logic [2:0] cmd);
    logic [UAW-1:0] a;
    a = U_E_OK;
    case (cmd)
      CMD_RESTACK: a = U_RS_INIT;
      CMD_SHUFFLE: a = U_SH_CHK0;
      CMD_DEAL:    a = U_DT_CHK;
      CMD_HAND:    a = U_DH_CHK;
      CMD_PEEK:    a = U_PK_CHK;
      CMD_REPLACE: a = U_RP_CHK;
      default:     a = U_E_OK;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/card_deck_shuffle_dealer.sv =====
// ----------------------------------------------------------------------------
// card_deck_shuffle_dealer: card deck store with one-swap-per-item shuffle
// Microcoded controller over a deck RAM, count/cursor registers and a
// bit-serial remainder unit.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, random word, card id) is taken at a clock edge with
//   start high and busy low. busy stays high until the item's last result
//   has been produced. Each result item shows on res_o for exactly one cycle
//   with res_valid_o high; there is no backpressure, the receiver must take
//   it. The strobe of a single-result item appears in the cycle busy falls;
//   a hand strobes once per card, its last card in the final busy
//   cycle, so a new start may follow right after.
//   A shuffle step runs 31 remainder steps, one bit per cycle, then a
//   read-read-write-write swap through the deck RAM's read and write
//   ports; a hand takes one RAM read per card.
//   Reset clears card count, shuffle cursor and the controller; the deck RAM
//   is not cleared, since nothing reads it before a restack fills it.
// ----------------------------------------------------------------------------
module card_deck_shuffle_dealer #(
  parameter int DECK_SIZE = 64,
  parameter int HAND_SIZE = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cdsd_pkg::in_t    item_i,
  output cdsd_pkg::out_t   res_o,
  output logic             res_valid_o
);
  import cdsd_pkg::*;

  localparam int AW  = $clog2(DECK_SIZE);        // deck address
  localparam int CW  = $clog2(DECK_SIZE + 1);    // card count
  localparam int HCW = $clog2(HAND_SIZE + 1);
  localparam int IW  = (CW > HCW) ? CW : HCW;    // loop index

  logic   go;
  ucode_t uw;
  flags_t flags;

  // captured item
  logic [2:0]      cmd_q;
  logic [RNDW-1:0] rnd_q, rnd_d;
  logic [7:0]      id_q;

  // architectural state
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] cursor_q, cursor_d;

  // work registers
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   span_q, span_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [BITW-1:0] bit_q, bit_d;
  logic [AW-1:0]   pick_q, pick_d;
  logic [7:0]      hold_q, hold_d;
  logic [7:0]      card_q, card_d;
  logic [CW:0]     trial;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // result register
  out_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  assign go = start && !busy;

  assign flags.empty_deck = (count_q == '0);
  assign flags.few_cards  = (IW'(count_q) < IW'(HAND_SIZE));
  assign flags.shuf_done  = ((CW'(cursor_q) + CW'(1)) >= count_q);
  assign flags.fill_last  = (idx_q == IW'(DECK_SIZE - 1));
  assign flags.div_last   = (bit_q == '0);
  assign flags.hand_last  = (idx_q == IW'(HAND_SIZE - 1));

  cdsd_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .cmd_i   (cmd_q),
    .flags_i (flags),
    .busy_o  (busy),
    .uw_o    (uw)
  );

  cdsd_ram #(
    .WIDTH (8),
    .DEPTH (DECK_SIZE)
  ) u_deck (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // restoring remainder: shift in one random bit, subtract span if it fits
  assign trial = {rem_q, rnd_q[RNDW-1]};

  // datapath, one action per program step
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    idx_d    = idx_q;
    span_d   = span_q;
    rem_d    = rem_q;
    bit_d    = bit_q;
    rnd_d    = rnd_q;
    pick_d   = pick_q;
    hold_d   = hold_q;
    card_d   = card_q;
    we       = 1'b0;
    waddr    = cursor_q;
    wdata    = rdata;
    raddr    = cursor_q;
    if (go) begin
      rnd_d = item_i.random_value;
    end
    unique case (uw.act)
      A_NONE: ;
      A_IDX_CLR: idx_d = '0;
      A_RS_WR: begin
        we    = 1'b1;
        waddr = AW'(idx_q);
        wdata = 8'(idx_q);
        idx_d = idx_q + IW'(1);
      end
      A_RS_FIN: begin
        count_d  = CW'(DECK_SIZE);
        cursor_d = '0;
      end
      A_DIV_INIT: begin
        span_d = count_q - CW'(cursor_q);
        rem_d  = '0;
        bit_d  = BITW'(RNDW - 1);
      end
      A_DIV_STEP: begin
        if (trial >= {1'b0, span_q}) begin
          rem_d = CW'(trial - {1'b0, span_q});
        end else begin
          rem_d = trial[CW-1:0];
        end
        rnd_d = {rnd_q[RNDW-2:0], 1'b0};
        bit_d = bit_q - BITW'(1);
      end
      A_PICK: begin
        pick_d = cursor_q + rem_q[AW-1:0];   // rem < span, so it fits
        raddr  = cursor_q;
      end
      A_HOLD: begin
        hold_d = rdata;                      // entry at cursor
        raddr  = pick_q;
      end
      A_SW1: begin
        we    = 1'b1;                        // entry at pick into cursor
        waddr = cursor_q;
        wdata = rdata;
      end
      A_SW2: begin
        we       = 1'b1;
        waddr    = pick_q;
        wdata    = hold_q;
        cursor_d = cursor_q + AW'(1);
      end
      A_DEC:     count_d = count_q - CW'(1);
      A_RD_TOP:  raddr = count_q[AW-1:0];    // already decremented, below DECK_SIZE
      A_LOAD:    card_d = rdata;
      A_IDX_INC: idx_d = idx_q + IW'(1);
      A_RD_BOT:  raddr = '0;
      A_WR_BOT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = id_q;
      end
      default: ;
    endcase
  end

  // result formatting
  always_comb begin
    res_valid_d         = (uw.emit != EM_NONE);
    res_d.card          = '0;
    res_d.cards_remaining = 7'(count_q);
    res_d.deck_empty    = (count_q == '0);
    res_d.status        = ST_OK;
    res_d.last          = 1'b1;
    case (uw.emit)
      EM_CARD: res_d.card = card_q;
      EM_HAND: begin
        res_d.card = card_q;
        res_d.last = flags.hand_last;
      end
      EM_UNDER: res_d.status = ST_UNDER;
      EM_DONE:  res_d.status = ST_DONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      cmd_q <= item_i.command;
      id_q  <= item_i.card_id;
    end
    rnd_q  <= rnd_d;
    idx_q  <= idx_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    pick_q <= pick_d;
    hold_q <= hold_d;
    card_q <= card_d;
    res_q  <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// ===== rtl/core/cdsd_ram.sv =====
// ----------------------------------------------------------------------------
// cdsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cdsd_useq.sv =====
// ----------------------------------------------------------------------------
// cdsd_useq: control sequencer
// Step counter over the read-only program, with branch and dispatch.
// ----------------------------------------------------------------------------
module cdsd_useq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [2:0]                cmd_i,
  input  cdsd_pkg::flags_t          flags_i,
  output logic                      busy_o,
  output cdsd_pkg::ucode_t          uw_o
);
  import cdsd_pkg::*;

  logic           run_q, run_d;
  logic [UAW-1:0] upc_q, upc_d;
  ucode_t         uw;
  logic           cond;

  assign uw = run_q ? ucode_rom(upc_q) : UW_NOP;

  always_comb begin
    unique case (uw.cond)
      C_EMPTY:     cond = flags_i.empty_deck;
      C_FEW:       cond = flags_i.few_cards;
      C_SHUF_DONE: cond = flags_i.shuf_done;
      C_FILL_LAST: cond = flags_i.fill_last;
      C_DIV_LAST:  cond = flags_i.div_last;
      C_HAND_LAST: cond = flags_i.hand_last;
      default:     cond = 1'b0;
    endcase
  end

  always_comb begin
    run_d = run_q;
    upc_d = upc_q;
    if (go_i) begin
      run_d = 1'b1;
      upc_d = U_DISPATCH;
    end else if (run_q) begin
      unique case (uw.seq)
        SEQ_NEXT:     upc_d = upc_q + UAW'(1);
        SEQ_JUMP:     upc_d = uw.target;
        SEQ_BRANCH:   upc_d = (cond ^ uw.inv) ? uw.target : upc_q + UAW'(1);
        SEQ_DISPATCH: upc_d = dispatch(cmd_i);
        SEQ_END:      run_d = 1'b0;
        default:      run_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      upc_q <= U_DISPATCH;
    end else begin
      run_q <= run_d;
      upc_q <= upc_d;
    end
  end

  assign busy_o = run_q;
  assign uw_o   = uw;

endmodule

// ===== tb/tb_card_deck_shuffle_dealer.sv =====
// ----------------------------------------------------------------------------
// tb_card_deck_shuffle_dealer: self-checking bench for the card deck dealer
// Drives command items through the start/busy handshake and keeps its own
// deck, card count and shuffle cursor to predict every result item. Each
// strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_card_deck_shuffle_dealer;
  timeunit 1ns;
  timeprecision 1ps;

  import cdsd_pkg::*;

  localparam int DECK_SIZE    = 64;
  localparam int HAND_SIZE    = 8;
  // covers the longest job, a restack, plus the longest sender gap
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = DECK_SIZE + 16;
  localparam int RANDOM_ITEMS = 120;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  item_i = '0;
  logic busy;
  out_t res_o;
  logic res_valid_o;

  always #5 clk_i = ~clk_i;

  card_deck_shuffle_dealer #(
    .DECK_SIZE(DECK_SIZE),
    .HAND_SIZE(HAND_SIZE)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  // --------------------------------------------------------------------------
  // Deck predictor state: mirrors the block after every accepted item.
  // --------------------------------------------------------------------------
  logic [7:0]  deck_q [DECK_SIZE];
  int unsigned cards_left = 0;
  int unsigned cursor     = 0;

  out_t due_q [$];              // predicted result items, oldest first
  out_t want_res;

  int fail_count      = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int quiet_cycles    = 0;
  int idle_max        = 11;     // sender gap upper bound, 0 for back-to-back
  int cmd_hits [8];

  function automatic in_t deck_item(logic [2:0] cmd, logic [RNDW-1:0] rnd,
                                    logic [7:0] id);
    in_t it;
    it.command      = cmd;
    it.random_value = rnd;
    it.card_id      = id;
    return it;
  endfunction

  // random word and card id, full range of both
  function automatic in_t random_item(logic [2:0] cmd);
    return deck_item(cmd, RNDW'($urandom), 8'($urandom_range(0, 255)));
  endfunction

  // result seen after the state change; count and empty flag follow it
  task automatic push_result(logic [7:0] card, status_e st, logic lst);
    out_t r;
    r.card            = card;
    r.cards_remaining = 7'(cards_left);
    r.deck_empty      = (cards_left == 0);
    r.status          = st;
    r.last            = lst;
    due_q = {due_q, r};
  endtask

  task automatic predict_deck_cmd(in_t it);
    int unsigned span;
    int unsigned pick;
    logic [7:0]  tmp;
    cmd_hits[it.command]++;
    case (it.command)
      CMD_RESTACK: begin
        // whole deck replaced, shuffle rewinds
        for (int i = 0; i < DECK_SIZE; i++) deck_q[i] = 8'(i);
        cards_left = DECK_SIZE;
        cursor     = 0;
        push_result(8'd0, ST_OK, 1'b1);
      end
      CMD_SHUFFLE: begin
        if (cards_left == 0) begin
          push_result(8'd0, ST_UNDER, 1'b1);
        end else if (cursor + 1 >= cards_left) begin
          // covers a cursor stranded above the top by deals
          push_result(8'd0, ST_DONE, 1'b1);
        end else begin
          span = cards_left - cursor;
          pick = cursor + int'(it.random_value) % span;
          tmp          = deck_q[pick];
          deck_q[pick] = deck_q[cursor];
          deck_q[cursor] = tmp;
          cursor++;
          push_result(8'd0, ST_OK, 1'b1);
        end
      end
      CMD_DEAL: begin
        if (cards_left == 0) begin
          push_result(8'd0, ST_UNDER, 1'b1);
        end else begin
          cards_left--;
          push_result(deck_q[cards_left], ST_OK, 1'b1);
        end
      end
      CMD_HAND: begin
        // short deck: one underflow item, nothing removed
        if (cards_left < HAND_SIZE) begin
          push_result(8'd0, ST_UNDER, 1'b1);
        end else begin
          for (int n = 0; n < HAND_SIZE; n++) begin
            cards_left--;
            push_result(deck_q[cards_left], ST_OK, n == HAND_SIZE - 1);
          end
        end
      end
      CMD_PEEK: begin
        if (cards_left == 0) push_result(8'd0, ST_UNDER, 1'b1);
        else push_result(deck_q[0], ST_OK, 1'b1);
      end
      CMD_REPLACE: begin
        if (cards_left == 0) begin
          push_result(8'd0, ST_UNDER, 1'b1);
        end else begin
          deck_q[0] = it.card_id;
          push_result(8'd0, ST_OK, 1'b1);
        end
      end
      default: push_result(8'd0, ST_OK, 1'b1);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender. start is left high after acceptance; busy masks it until the
  // next call either lowers it for a gap or puts the next item up, so start
  // gets a single update per falling edge.
  // --------------------------------------------------------------------------
  task automatic send_item(in_t it);
    int gap;
    gap = $urandom_range(0, idle_max);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_deck_cmd(it);
    items_sent++;
  endtask

  // sender holds off until every predicted item has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    start <= 1'b0;
    wait (due_q.size() == 0);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: no backpressure, so every strobe is an accepted item.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      if (due_q.size() == 0) begin
        $error("result item with nothing expected: card %0d status %0d",
               res_o.card, res_o.status);
        fail_count++;
      end else begin
        want_res = due_q.pop_front();
        check_field("card", want_res.card, res_o.card);
        check_field("cards_remaining", want_res.cards_remaining, res_o.cards_remaining);
        check_field("deck_empty", want_res.deck_empty, res_o.deck_empty);
        check_field("status", want_res.status, res_o.status);
        check_field("last", want_res.last, res_o.last);
        results_checked++;
      end
    end
  end

  // watchdog: any accepted item or result strobe counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || res_valid_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no progress for %0d cycles, %0d results still due",
               QUIET_LIMIT, due_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // fresh after reset: every deck command underflows, spare codes are no-ops
  task automatic test_empty_deck();
    send_item(random_item(CMD_DEAL));
    send_item(random_item(CMD_HAND));
    send_item(random_item(CMD_PEEK));
    send_item(random_item(CMD_REPLACE));
    send_item(random_item(CMD_SHUFFLE));
    send_item(random_item(CMD_SPARE6));
    send_item(random_item(CMD_SPARE7));
  endtask

  // bottom card write/read with an all-ones id, shuffle with word extremes
  task automatic test_bottom_card();
    send_item(deck_item(CMD_RESTACK, '0, 8'h00));
    send_item(deck_item(CMD_REPLACE, '0, 8'hFF));
    send_item(deck_item(CMD_PEEK, '1, 8'h00));
    send_item(deck_item(CMD_SHUFFLE, '0, 8'hFF));
    send_item(deck_item(CMD_SHUFFLE, '1, 8'h00));
  endtask

  // deal the deck down with hands back to back, then hit the stranded
  // cursor (shuffle complete) and a short-deck hand
  task automatic test_deal_down();
    idle_max = 0;
    repeat (7) send_item(random_item(CMD_HAND));
    idle_max = 11;
    repeat (5) send_item(random_item(CMD_DEAL));
    wait_for_results();
    send_item(random_item(CMD_SHUFFLE));
    send_item(random_item(CMD_HAND));
  endtask

  // rounds of restack, a run of shuffle steps and random play; some rounds
  // are pure noise over all eight command codes
  task automatic test_random_rounds();
    int         goal;
    int         steps;
    int         roll;
    logic [2:0] cmd;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(3, 8)) send_item(random_item(3'($urandom_range(0, 7))));
      end else begin
        send_item(random_item(CMD_RESTACK));
        // now and then run the shuffle all the way to completion
        steps = ($urandom_range(0, 4) == 0) ? DECK_SIZE : $urandom_range(2, 16);
        repeat (steps) send_item(random_item(CMD_SHUFFLE));
        repeat ($urandom_range(4, 14)) begin
          roll = $urandom_range(0, 99);
          if (roll < 30)      cmd = CMD_DEAL;
          else if (roll < 55) cmd = CMD_HAND;
          else if (roll < 75) cmd = CMD_PEEK;
          else if (roll < 95) cmd = CMD_REPLACE;
          else                cmd = CMD_SHUFFLE;
          send_item(random_item(cmd));
        end
      end
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_deck();
    test_bottom_card();
    test_deal_down();
    test_random_rounds();

    // let the last job finish, then watch for stray strobes
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run: %0d items (restack %0d, shuffle %0d, deal %0d, hand %0d, peek %0d,",
             items_sent, cmd_hits[CMD_RESTACK], cmd_hits[CMD_SHUFFLE],
             cmd_hits[CMD_DEAL], cmd_hits[CMD_HAND], cmd_hits[CMD_PEEK]);
    $display("     replace %0d, spare codes %0d), %0d result items checked",
             cmd_hits[CMD_REPLACE], cmd_hits[CMD_SPARE6] + cmd_hits[CMD_SPARE7],
             results_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cdsd_pkg.sv
rtl/core/cdsd_ram.sv
rtl/core/cdsd_useq.sv
rtl/core/card_deck_shuffle_dealer.sv
tb/tb_card_deck_shuffle_dealer.sv
